// File: src/assert_macros.svh
// Assertion macros for the compressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property at every rising clk edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression never holds outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    `ASSERT_CLK(lbl, !(expr), msg)

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// File: src/lzwc_pkg.sv
// Types and constants shared by the LZW byte compressor modules.
package lzwc_pkg;

    localparam int CODE_BITS  = 12;
    localparam int HASH_SLOTS = 8192;
    localparam int HASH_BITS  = $clog2(HASH_SLOTS);
    localparam int EPOCH_BITS = 4;
    localparam int SYM_BITS   = 8;

    localparam int S_TDATA_W = SYM_BITS;
    localparam int M_TDATA_W = ((CODE_BITS + 7) / 8) * 8;

    localparam logic [CODE_BITS:0]    FIRST_CODE = (CODE_BITS + 1)'(256);
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
    localparam logic [HASH_BITS-1:0]  SLOT_LAST   = HASH_BITS'(HASH_SLOTS - 1);

    // One dictionary slot; a slot is live only when its epoch matches the current one.
    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [CODE_BITS-1:0]  prefix;
        logic [SYM_BITS-1:0]   sym;
        logic [CODE_BITS-1:0]  code;
    } lzwc_entry_t;

    localparam int ENTRY_W = $bits(lzwc_entry_t);

    // Code handed from the controller to the output stage.
    typedef struct packed {
        logic                 vld;
        logic [CODE_BITS-1:0] code;
        logic                 eos;
    } lzwc_emit_t;

    // Start slot of the probe: (prefix * 256 + sym) mod HASH_SLOTS.
    function automatic logic [HASH_BITS-1:0] hash_idx(
        input logic [CODE_BITS-1:0] prefix,
        input logic [SYM_BITS-1:0]  sym
    );
        logic [CODE_BITS+SYM_BITS-1:0] key;
        begin
            key = {prefix, sym};
            return key[HASH_BITS-1:0];
        end
    endfunction

endpackage

// File: src/lzwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lzwc_out.sv
// Output register stage for emitted codes.
module lzwc_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lzwc_pkg::lzwc_emit_t          emit,
    output logic                          emit_rdy,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lzwc_pkg::M_TDATA_W-1:0] m_tdata,   // [11:0] out_code, rest zero
    output logic                          m_tlast     // end_of_stream
);

    import lzwc_pkg::*;

    logic                 valid_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic                 eos_reg;

    assign emit_rdy = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_rdy)
        begin
            valid_reg <= emit.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_rdy && emit.vld)
        begin
            code_reg <= emit.code;
            eos_reg  <= emit.eos;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'(code_reg);
    assign m_tlast  = eos_reg;

endmodule

// File: src/lzwc_ctrl.sv
// Dictionary controller: hashed lookup with linear probing, insert and epoch clearing.
`include "assert_macros.svh"

module lzwc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lzwc_pkg::SYM_BITS-1:0]  in_sym,
    input  logic                           in_last,
    output lzwc_pkg::lzwc_emit_t           emit,
    input  logic                           emit_rdy,
    output logic                           ram_we,
    output logic [lzwc_pkg::HASH_BITS-1:0] ram_waddr,
    output lzwc_pkg::lzwc_entry_t          ram_wdata,
    output logic                           ram_re,
    output logic [lzwc_pkg::HASH_BITS-1:0] ram_raddr,
    input  lzwc_pkg::lzwc_entry_t          ram_rdata
);

    import lzwc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_EMIT_MISS,
        ST_EMIT_LAST
    } state_t;

    state_t                state_reg, state_next;
    logic [CODE_BITS-1:0]  prefix_reg, prefix_next;
    logic                  have_reg, have_next;
    logic [CODE_BITS:0]    next_code_reg, next_code_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [HASH_BITS-1:0]  idx_reg, idx_next;
    logic [HASH_BITS-1:0]  cnt_reg, cnt_next;
    logic [SYM_BITS-1:0]   sym_reg, sym_next;
    logic                  last_reg, last_next;
    logic [CODE_BITS-1:0]  miss_code_reg, miss_code_next;

    logic take;
    logic slot_live;
    logic slot_hit;
    logic dict_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    assign slot_live = (ram_rdata.epoch == epoch_reg);
    assign slot_hit  = slot_live && (ram_rdata.prefix == prefix_reg)
                       && (ram_rdata.sym == sym_reg);
    assign dict_full = next_code_reg[CODE_BITS];

    always_comb
    begin
        emit.vld  = (state_reg == ST_EMIT_MISS) || (state_reg == ST_EMIT_LAST);
        emit.code = (state_reg == ST_EMIT_MISS) ? miss_code_reg : prefix_reg;
        emit.eos  = (state_reg == ST_EMIT_LAST);
    end

    always_comb
    begin
        state_next     = state_reg;
        prefix_next    = prefix_reg;
        have_next      = have_reg;
        next_code_next = next_code_reg;
        epoch_next     = epoch_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        miss_code_next = miss_code_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = hash_idx(prefix_reg, in_sym);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every slot back to the dead epoch.
                ram_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (take)
                begin
                    sym_next  = in_sym;
                    last_next = in_last;
                    if (!have_reg)
                    begin
                        prefix_next = CODE_BITS'(in_sym);
                        have_next   = 1'b1;
                        if (in_last)
                        begin
                            state_next = ST_EMIT_LAST;
                        end
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        idx_next   = hash_idx(prefix_reg, in_sym);
                        cnt_next   = '0;
                        state_next = ST_PROBE;
                    end
                end
            end

            ST_PROBE:
            begin
                if (slot_hit)
                begin
                    prefix_next = ram_rdata.code;
                    state_next  = last_reg ? ST_EMIT_LAST : ST_IDLE;
                end
                else if (!slot_live || (cnt_reg == SLOT_LAST))
                begin
                    // Not found: emit prefix; learn pair at a free slot if codes remain.
                    if (!slot_live && !dict_full)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.epoch  = epoch_reg;
                        ram_wdata.prefix = prefix_reg;
                        ram_wdata.sym    = sym_reg;
                        ram_wdata.code   = next_code_reg[CODE_BITS-1:0];
                        next_code_next   = next_code_reg + 1'b1;
                    end
                    miss_code_next = prefix_reg;
                    prefix_next    = CODE_BITS'(sym_reg);
                    state_next     = ST_EMIT_MISS;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end

            ST_EMIT_MISS:
            begin
                if (emit_rdy)
                begin
                    state_next = last_reg ? ST_EMIT_LAST : ST_IDLE;
                end
            end

            ST_EMIT_LAST:
            begin
                if (emit_rdy)
                begin
                    prefix_next    = '0;
                    have_next      = 1'b0;
                    next_code_next = FIRST_CODE;
                    // Retire the epoch; sweep the table once the tag space runs out.
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        epoch_next = EPOCH_FIRST;
                        idx_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            prefix_reg    <= '0;
            have_reg      <= 1'b0;
            next_code_reg <= FIRST_CODE;
            epoch_reg     <= EPOCH_FIRST;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prefix_reg    <= prefix_next;
            have_reg      <= have_next;
            next_code_reg <= next_code_next;
            epoch_reg     <= epoch_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        miss_code_reg <= miss_code_next;
    end

    `ASSERT_NEVER(a_code_range, next_code_reg > (FIRST_CODE << (CODE_BITS - 8)), "next code past limit")
    `ASSERT_NEVER(a_epoch_nonzero, epoch_reg == '0, "current epoch equals dead tag")
    `ASSERT_CLK(a_emit_hold, (emit.vld && !emit_rdy) |=> (emit.vld && $stable(emit.code) && $stable(emit.eos)), "pending code changed before taken")
    `ASSERT_CLK(a_probe_read, (state_reg == ST_PROBE && state_next == ST_PROBE) |-> ram_re, "probe continues without a read")

endmodule

// File: src/lzw_byte_compressor.sv
// Top level of the 12-bit LZW byte compressor.
//
//   channel | dir | tdata                      | tlast
//   s_*     | in  | [7:0] data_byte            | is_last
//   m_*     | out | [11:0] out_code, [15:12] 0 | end_of_stream
//
// A byte that starts a prefix is taken in the idle state; a dictionary lookup issues a
// read of the hashed slot and then probes the following slots one by one, and a byte
// that misses passes its code to the output register; the last byte flushes its code.
// The single dictionary RAM port reads one slot per cycle while probing.
// After reset, and after every 15th stream end, a clearing pass sweeps every
// dictionary slot while s_tready stays low.
// Stalls on m_tready hold the controller in its emit state; one code waits in the
// output register while the next byte is taken.
module lzw_byte_compressor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lzwc_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,   // is_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lzwc_pkg::M_TDATA_W-1:0] m_tdata,   // [11:0] out_code, rest zero
    output logic                           m_tlast    // end_of_stream
);

    import lzwc_pkg::*;

    lzwc_emit_t           emit;
    logic                 emit_rdy;
    logic                 ram_we;
    logic [HASH_BITS-1:0] ram_waddr;
    lzwc_entry_t          ram_wdata;
    logic                 ram_re;
    logic [HASH_BITS-1:0] ram_raddr;
    lzwc_entry_t          ram_rdata;

    lzwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sym    (s_tdata[SYM_BITS-1:0]),
        .in_last   (s_tlast),
        .emit      (emit),
        .emit_rdy  (emit_rdy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HASH_SLOTS)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lzwc_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .emit_rdy (emit_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
